@@ design/lbb_pkg.sv @@
// Shared types and constants of the LED blink and breath generator.
package lbb_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned DUTY_W      = 10;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned PROD_W      = 2 * LEVEL_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] PAT_STEADY = 2'd0;
  localparam logic [1:0] PAT_FLASH  = 2'd1;
  localparam logic [1:0] PAT_BREATH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_ON      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LIMIT    = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STEADY = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TIME_W-1:0] elapsed_ms;
  } q_item_t;

  typedef struct packed {
    logic [1:0]        pattern_select;
    logic              steady_on;
    logic [TIME_W-1:0] period_ms;
    logic [TIME_W-1:0] pulse_ms;
    logic [TIME_W-1:0] cycle_limit;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ design/lbb_in_if.sv @@
// Input channel: start and tick transactions.
interface lbb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [lbb_pkg::TIME_W-1:0]  elapsed_ms;

  modport source (output valid, mode, elapsed_ms, input ready);
  modport sink   (input valid, mode, elapsed_ms, output ready);
endinterface

@@ design/lbb_out_if.sv @@
// Result channel: PWM duty and pattern status.
interface lbb_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbb_pkg::DUTY_W-1:0]  duty;
  logic                        running;
  logic                        finished;

  modport source (output valid, duty, running, finished, input ready);
  modport sink   (input valid, duty, running, finished, output ready);
endinterface

@@ design/led_blink_breath_generator.sv @@
// Top level of the LED blink and breath PWM pattern generator.
// Each input transaction (a start or a millisecond tick) yields exactly one result
// transaction carrying the PWM duty out of DUTY_FULL, the running flag and the finished
// flag. A two-entry command queue sits between the input side and the pattern engine,
// and a result register decouples the output, so input transactions keep being taken
// while the engine works or a result waits, as long as the queue has a free entry.
// Starts, steady ticks and flash ticks do not use the divider; a breath tick inside the
// period runs one 32-step pass through the radix-2 divider for the ramp level, followed
// by gamma steps (square, multiply by a reciprocal of DUTY_FULL, check, fix).
// Registers take effect on the next start; write them only while the block is idle.
module led_blink_breath_generator #(
  parameter int unsigned DUTY_FULL = 1000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data,
  lbb_in_if.sink                         in_chan,
  lbb_out_if.source                      out_chan
);
  import lbb_pkg::*;

  cfg_t     cfg;
  logic     head_valid;
  q_item_t  head;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  lbb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_chan    (in_chan),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lbb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lbb_engine #(
    .DUTY_FULL (DUTY_FULL)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_chan   (out_chan)
  );

endmodule

@@ design/lbb_front.sv @@
// Front end: configuration registers, transaction classification and command queue.
module lbb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data,
  lbb_in_if.sink                         in_chan,
  output lbb_pkg::cfg_t                  cfg,
  output logic                           head_valid,
  output lbb_pkg::q_item_t               head,
  input  logic                           pop
);
  import lbb_pkg::*;

  cfg_t             cfg_r;
  q_item_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  q_item_t          item;
  logic             push, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_SELECT: cfg_r.pattern_select <= cfg_data[1:0];
        REG_STEADY_ON:      cfg_r.steady_on      <= cfg_data[0];
        REG_PERIOD_MS:      cfg_r.period_ms      <= cfg_data[TIME_W-1:0];
        REG_PULSE_MS:       cfg_r.pulse_ms       <= cfg_data[TIME_W-1:0];
        REG_CYCLE_LIMIT:    cfg_r.cycle_limit    <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify: a start either loads a timed pattern or falls back to steady.
  always_comb begin
    item.elapsed_ms = in_chan.elapsed_ms;
    if (!in_chan.mode) begin
      item.cmd = CMD_TICK;
    end else if (cfg_r.pattern_select == PAT_FLASH || cfg_r.pattern_select == PAT_BREATH) begin
      item.cmd = CMD_LOAD;
    end else begin
      item.cmd = CMD_STEADY;
    end
  end

  assign in_chan.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign take          = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !take) begin
        count_r <= count_r + 1'b1;
      end else if (take && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign cfg        = cfg_r;
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

endmodule

@@ design/lbb_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module lbb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lbb_pkg::div_req_t  req,
  output lbb_pkg::div_rsp_t  rsp
);
  import lbb_pkg::*;

  localparam int unsigned STEPS = PROD_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [LEVEL_W-1:0] rem_r, den_r;
  logic [PROD_W-1:0]  quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic [LEVEL_W:0]   shifted, diff;
  logic               ge;

  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[LEVEL_W-1:0] : shifted[LEVEL_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ design/lbb_engine.sv @@
// Back end: pattern state, timer, breath ramp with gamma, and the result register.
module lbb_engine #(
  parameter int unsigned DUTY_FULL = 1000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lbb_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  lbb_pkg::q_item_t  head,
  output logic              pop,
  output lbb_pkg::div_req_t div_req,
  input  lbb_pkg::div_rsp_t div_rsp,
  lbb_out_if.source         out_chan
);
  import lbb_pkg::*;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(DUTY_FULL);
  localparam logic [DUTY_W-1:0]  FULL_DUTY  = DUTY_W'(DUTY_FULL);

  // Reciprocal of full scale, floor(2^32 / DUTY_FULL); the estimate it gives for
  // level*level / DUTY_FULL is at most one low, which one compare fixes.
  localparam int unsigned     RCP_W      = 25;
  localparam int unsigned     RPROD_W    = PROD_W + RCP_W;
  localparam longint unsigned RECIP_FULL = 64'h1_0000_0000 / 64'(DUTY_FULL);
  localparam logic [RCP_W-1:0] RECIP     = RCP_W'(RECIP_FULL);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_TIME = 10'b00_0000_0010,
    S_EVAL = 10'b00_0000_0100,
    S_MUL  = 10'b00_0000_1000,
    S_DIV  = 10'b00_0001_0000,
    S_SQR  = 10'b00_0010_0000,
    S_RCP  = 10'b00_0100_0000,
    S_CHK  = 10'b00_1000_0000,
    S_FIX  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         active_r, active_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]  cycles_r, cycles_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic               finished_r, finished_nxt;
  logic [TIME_W-1:0]  period_r, period_nxt;
  logic [TIME_W-1:0]  pulse_r, pulse_nxt;
  logic [TIME_W-1:0]  tick_r, tick_nxt;
  logic [LEVEL_W-1:0] x_r, x_nxt;
  logic [LEVEL_W-1:0] den_r, den_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [PROD_W-1:0]  sq_r, sq_nxt;
  logic [LEVEL_W-1:0] q0_r, q0_nxt;
  logic [PROD_W-1:0]  qd_r, qd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_running_r, out_finished_r;
  logic               load_out;

  logic [TIME_W:0]    sum;
  logic               ge_pulse, ge_period, last_cycle;
  logic [DUTY_W-1:0]  restart_duty;
  logic [RPROD_W-1:0] rprod;

  assign sum        = {1'b0, elapsed_r} + {1'b0, tick_r};
  assign ge_pulse   = (elapsed_r >= pulse_r);
  assign ge_period  = (elapsed_r >= period_r);
  assign last_cycle = (cycles_r == TIME_W'(1));
  assign load_out   = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
  assign rprod      = RPROD_W'(sq_r) * RPROD_W'(RECIP);

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    elapsed_nxt  = elapsed_r;
    cycles_nxt   = cycles_r;
    duty_nxt     = duty_r;
    finished_nxt = finished_r;
    period_nxt   = period_r;
    pulse_nxt    = pulse_r;
    tick_nxt     = tick_r;
    x_nxt        = x_r;
    den_nxt      = den_r;
    level_nxt    = level_r;
    sq_nxt       = sq_r;
    q0_nxt       = q0_r;
    qd_nxt       = qd_r;
    pop          = 1'b0;
    div_req      = '0;
    restart_duty = (active_r == PAT_FLASH) ? FULL_DUTY : '0;

    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop          = 1'b1;
          finished_nxt = 1'b0;
          tick_nxt     = head.elapsed_ms;
          state_nxt    = S_DONE;
          case (head.cmd)
            CMD_LOAD: begin
              active_nxt  = cfg.pattern_select;
              period_nxt  = cfg.period_ms;
              pulse_nxt   = cfg.pulse_ms;
              cycles_nxt  = cfg.cycle_limit;
              elapsed_nxt = '0;
              duty_nxt    = '0;
            end
            CMD_STEADY: begin
              active_nxt = PAT_STEADY;
              duty_nxt   = cfg.steady_on ? FULL_DUTY : '0;
            end
            default: begin
              // Steady ticks repeat the held duty.
              if (active_r == PAT_FLASH || active_r == PAT_BREATH) begin
                state_nxt = S_TIME;
              end
            end
          endcase
        end
      end
      S_TIME: begin
        // Saturate the period timer.
        elapsed_nxt = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (active_r == PAT_FLASH && ge_pulse) begin
          duty_nxt = '0;
        end
        if (active_r == PAT_BREATH && !ge_period) begin
          x_nxt     = ge_pulse ? (period_r - elapsed_r) : elapsed_r;
          den_nxt   = ge_pulse ? (period_r - pulse_r) : pulse_r;
          state_nxt = S_MUL;
        end else if (ge_period) begin
          if (cycles_r != '0) begin
            cycles_nxt = cycles_r - 1'b1;
          end
          if (last_cycle) begin
            active_nxt   = PAT_STEADY;
            duty_nxt     = '0;
            finished_nxt = 1'b1;
          end else begin
            elapsed_nxt = '0;
            duty_nxt    = restart_duty;
          end
        end
      end
      S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = PROD_W'(FULL_LEVEL) * PROD_W'(x_r);
        div_req.divisor  = den_r;
        state_nxt        = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          level_nxt = div_rsp.quotient[LEVEL_W-1:0];
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        // Gamma: level squared over full scale.
        sq_nxt    = PROD_W'(level_r) * PROD_W'(level_r);
        state_nxt = S_RCP;
      end
      S_RCP: begin
        q0_nxt    = rprod[PROD_W +: LEVEL_W];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        qd_nxt    = (PROD_W'(q0_r) + 1'b1) * PROD_W'(FULL_LEVEL);
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // Bump the estimate when one more full scale still fits.
        duty_nxt  = (sq_r >= qd_r) ? (q0_r[DUTY_W-1:0] + 1'b1) : q0_r[DUTY_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= PAT_STEADY;
      elapsed_r   <= '0;
      cycles_r    <= '0;
      duty_r      <= '0;
      finished_r  <= 1'b0;
      period_r    <= '0;
      pulse_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      elapsed_r   <= elapsed_nxt;
      cycles_r    <= cycles_nxt;
      duty_r      <= duty_nxt;
      finished_r  <= finished_nxt;
      period_r    <= period_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r  <= tick_nxt;
    x_r     <= x_nxt;
    den_r   <= den_nxt;
    level_r <= level_nxt;
    sq_r    <= sq_nxt;
    q0_r    <= q0_nxt;
    qd_r    <= qd_nxt;
    if (load_out) begin
      out_duty_r     <= duty_r;
      out_running_r  <= (active_r == PAT_FLASH || active_r == PAT_BREATH);
      out_finished_r <= finished_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.duty     = out_duty_r;
  assign out_chan.running  = out_running_r;
  assign out_chan.finished = out_finished_r;

endmodule
